// ===== design/assert_macros.svh =====
// Assertion macros used by pixel_residual_block_golomb_param.sv.
// Define NO_ASSERTIONS to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/prbgp_pkg.sv =====
`timescale 1ns / 1ps

package prbgp_pkg;

    // Image geometry and field widths.
    localparam int MAX_WIDTH  = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int NCH        = 3;
    localparam int PIX_W      = 8;
    localparam int RES_W      = 9;
    localparam int SUM_W      = 24;
    localparam int CNT_W      = 16;
    localparam int IWID_W     = 13;
    localparam int PAR_W      = 8;

    // Configuration port.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // Stream widths.
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 56;
    localparam int OUT_PAD_W  = OUT_DATA_W - NCH * (RES_W + PAR_W);

    // Division by three as a multiplication by a scaled reciprocal.
    // Exact for every sum of three 8-bit samples.
    localparam int RECIP3_W     = 10;
    localparam int RECIP3       = 683;
    localparam int RECIP3_SHIFT = 11;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_IMAGE_WIDTH = 2'd0,
        CFG_BLOCK_SIZE  = 2'd1,
        CFG_ADAPTIVE    = 2'd2
    } t_cfg_idx;

    // A pixel: channel 0 (luma) in the lowest byte.
    typedef logic [NCH-1:0][PIX_W-1:0] t_pixel;

    // Residuals and their magnitudes for all channels.
    typedef struct packed {
        logic [NCH-1:0][RES_W-1:0] resid;
        logic [NCH-1:0][PIX_W-1:0] mag;
    } t_pred_res;

    // Request to the parameter divider.
    typedef struct packed {
        logic                      start;
        logic [CNT_W-1:0]          divisor;
        logic [NCH-1:0][SUM_W-1:0] dividend;
    } t_div_req;

endpackage

// ===== design/pixel_residual_block_golomb_param.sv =====
`timescale 1ns / 1ps
// Prediction residuals and per-block coding parameters for raster-order
// pixels with three 8-bit channels.
// Input stream: s_axis_tdata carries the three samples, s_axis_tuser marks
// the first pixel of an image. Output stream: m_axis_tdata carries three
// signed 9-bit residuals and three 8-bit parameters, m_axis_tuser flags a
// pixel that closes a block in adaptive mode.
// Each pixel passes two steps: the accept cycle issues the read of the
// previous-row memory; calculation forms the residuals, writes the pixel
// back and loads the output register, or waits for a full one in S_OUT.
// A pixel that closes a block in adaptive mode goes through S_DIV first,
// where the shift-subtract divider makes one quotient bit per cycle for
// all channels at once. A pixel is taken only when the block is idle; a
// stalled receiver holds the output register and the next pixel waits.
// Reset restores the register defaults and the start-of-image position;
// the previous-row memory is not cleared and needs no clearing pass.
// Registers are written through i_cfg_*; the user must write them only
// while the block is idle, which the block itself does not enforce.

`include "assert_macros.svh"

module pixel_residual_block_golomb_param (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Configuration writes.
    input  logic                                   i_cfg_we,
    input  logic [prbgp_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [prbgp_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    // Pixel input.
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // chan_luma, chan_red_diff, chan_blue_diff
    input  logic [prbgp_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    // frame_start
    input  logic [0:0]                             s_axis_tuser,
    // Result output.
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // resid_luma, resid_red_diff, resid_blue_diff, param_luma,
    // param_red_diff, param_blue_diff, zero padding
    output logic [prbgp_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // block_done
    output logic [0:0]                             m_axis_tuser
);

    import prbgp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_DIV,
        S_OUT
    } t_state;

    // Configuration registers.
    logic [IWID_W-1:0]         r_image_width;
    logic [CNT_W-1:0]          r_block_size;
    logic                      r_adaptive;

    // Control and position state.
    t_state                    r_state;
    logic [COL_W-1:0]          r_col;
    logic                      r_first_row;
    logic [CNT_W-1:0]          r_count;
    logic [NCH-1:0][SUM_W-1:0] r_sums;
    t_pixel                    r_left;
    t_pixel                    r_ul;

    // Transaction in flight.
    t_pixel                    r_cur;
    logic                      r_fs;
    logic [COL_W-1:0]          r_addr;
    logic [NCH-1:0][RES_W-1:0] r_res;
    logic                      r_flag;

    // Output register.
    logic                      r_out_valid;
    logic [NCH-1:0][RES_W-1:0] r_out_resid;
    logic                      r_out_done;
    logic [NCH-1:0][PAR_W-1:0] r_out_param;

    logic                      w_accept;
    logic                      w_slot_free;
    logic                      w_load;
    logic                      w_fs_in;
    logic [COL_W-1:0]          w_raddr;
    t_pixel                    w_above;
    t_pred_res                 w_pred;
    logic                      w_first_row;
    logic [CNT_W-1:0]          w_count_inc;
    logic [NCH-1:0][SUM_W-1:0] w_sums;
    logic [IWID_W-1:0]         w_width;
    logic [CNT_W-1:0]          w_bsize;
    logic                      w_wrap;
    logic                      w_end_block;
    logic                      w_calc;
    t_div_req                  w_div_req;
    logic                      w_div_done;
    logic [NCH-1:0][PAR_W-1:0] w_div_param;

    assign s_axis_tready = r_state == S_IDLE;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_slot_free   = !r_out_valid || m_axis_tready;
    assign w_fs_in       = s_axis_tuser[0];
    assign w_raddr       = w_fs_in ? '0 : r_col;
    assign w_calc        = r_state == S_CALC;
    assign w_load        = w_slot_free && ((w_calc && !w_div_req.start) || r_state == S_OUT);

    // Previous-row memory: read on acceptance, written back in calculation.
    prbgp_ram #(
        .WIDTH (IN_DATA_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (w_calc),
        .i_waddr (r_addr),
        .i_wdata (r_cur),
        .i_re    (w_accept),
        .i_raddr (w_raddr),
        .o_rdata (w_above)
    );

    // Residual datapath.
    prbgp_pred u_pred (
        .i_cur        (r_cur),
        .i_left       (r_left),
        .i_above      (w_above),
        .i_upper_left (r_ul),
        .i_first_row  (w_first_row),
        .i_col_zero   (r_addr == '0),
        .o_res        (w_pred)
    );

    // A frame start clears position, count and sums before the pixel is used.
    always_comb begin
        w_first_row = r_fs ? 1'b1 : r_first_row;
        w_count_inc = (r_fs ? '0 : r_count) + CNT_W'(1);
        for (int c = 0; c < NCH; c++) begin
            w_sums[c] = (r_fs ? '0 : r_sums[c]) + SUM_W'(w_pred.mag[c]);
        end

        if (r_image_width == '0) begin
            w_width = IWID_W'(1);
        end else if (r_image_width > IWID_W'(MAX_WIDTH)) begin
            w_width = IWID_W'(MAX_WIDTH);
        end else begin
            w_width = r_image_width;
        end
        w_bsize = (r_block_size == '0) ? CNT_W'(1) : r_block_size;

        w_wrap      = (IWID_W'(r_addr) + IWID_W'(1)) >= w_width;
        w_end_block = w_count_inc >= w_bsize;
    end

    // Block parameters: mean absolute residual per channel.
    assign w_div_req.start    = w_calc && w_end_block && r_adaptive;
    assign w_div_req.divisor  = w_bsize;
    assign w_div_req.dividend = w_sums;

    prbgp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_param (w_div_param)
    );

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= IWID_W'(640);
            r_block_size  <= CNT_W'(640);
            r_adaptive    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_IMAGE_WIDTH: r_image_width <= i_cfg_wdata[IWID_W-1:0];
                CFG_BLOCK_SIZE:  r_block_size  <= i_cfg_wdata[CNT_W-1:0];
                CFG_ADAPTIVE:    r_adaptive    <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Sequencer, pixel state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_first_row <= 1'b1;
            r_count     <= '0;
            r_sums      <= '0;
            r_left      <= '0;
            r_ul        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The output register fills on a load and empties on a handshake.
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_CALC;
                    end
                end

                S_CALC: begin
                    r_ul   <= w_above;
                    r_left <= r_cur;
                    if (w_wrap) begin
                        r_col       <= '0;
                        r_first_row <= 1'b0;
                    end else begin
                        r_col       <= r_addr + COL_W'(1);
                        r_first_row <= w_first_row;
                    end
                    if (w_end_block) begin
                        r_count <= '0;
                        r_sums  <= '0;
                    end else begin
                        r_count <= w_count_inc;
                        r_sums  <= w_sums;
                    end

                    if (w_div_req.start) begin
                        r_state <= S_DIV;
                    end else if (w_slot_free) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_OUT;
                    end
                end

                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_OUT;
                    end
                end

                S_OUT: begin
                    if (w_slot_free) begin
                        r_state <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Payload registers of the transaction in flight.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cur  <= s_axis_tdata;
            r_fs   <= w_fs_in;
            r_addr <= w_raddr;
        end
        if (w_calc) begin
            r_res  <= w_pred.resid;
            r_flag <= w_div_req.start;
        end
        if (w_calc && !w_div_req.start && w_slot_free) begin
            r_out_resid <= w_pred.resid;
            r_out_done  <= 1'b0;
            r_out_param <= '0;
        end else if (r_state == S_OUT && w_slot_free) begin
            r_out_resid <= r_res;
            r_out_done  <= r_flag;
            r_out_param <= r_flag ? w_div_param : '0;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = {{OUT_PAD_W{1'b0}}, r_out_param, r_out_resid};
    assign m_axis_tuser[0] = r_out_done;

    // An accepted pixel always goes straight to calculation.
    `ASSERT_NXT(a_accept_calc, i_clk, i_rst_n, w_accept, r_state == S_CALC)

    // A closed block never reports a zero parameter.
    `ASSERT_IMP(a_param_floor, i_clk, i_rst_n, r_out_valid && r_out_done,
        (r_out_param[0] != '0) && (r_out_param[1] != '0) && (r_out_param[2] != '0))

    // Parameters are zero on every other result.
    `ASSERT_IMP(a_param_zero, i_clk, i_rst_n, r_out_valid && !r_out_done,
        r_out_param == '0)

    // The divider finishes only while the sequencer waits for it.
    `ASSERT_IMP(a_div_state, i_clk, i_rst_n, w_div_done, r_state == S_DIV)

endmodule

// ===== design/prbgp_ram.sv =====
`timescale 1ns / 1ps

module prbgp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port. Read data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/prbgp_pred.sv =====
`timescale 1ns / 1ps

module prbgp_pred (
    input  prbgp_pkg::t_pixel    i_cur,
    input  prbgp_pkg::t_pixel    i_left,
    input  prbgp_pkg::t_pixel    i_above,
    input  prbgp_pkg::t_pixel    i_upper_left,
    input  logic                 i_first_row,
    input  logic                 i_col_zero,
    output prbgp_pkg::t_pred_res o_res
);

    import prbgp_pkg::*;

    localparam int TRI_W  = PIX_W + 2;
    localparam int PROD_W = TRI_W + RECIP3_W;

    logic [NCH-1:0][TRI_W-1:0]  w_tri;
    logic [NCH-1:0][PROD_W-1:0] w_prod;
    logic [NCH-1:0][PIX_W-1:0]  w_pred;
    logic [NCH-1:0][RES_W-1:0]  w_diff;
    logic [NCH-1:0][RES_W-1:0]  w_neg;

    // Per channel: pick the predictor, subtract, take the magnitude.
    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            w_tri[c] = TRI_W'(i_left[c]) + TRI_W'(i_above[c]) + TRI_W'(i_upper_left[c]);
            w_prod[c] = PROD_W'(w_tri[c]) * PROD_W'(RECIP3);

            if (i_first_row && i_col_zero) begin
                w_pred[c] = '0;
            end else if (i_first_row) begin
                w_pred[c] = i_left[c];
            end else if (i_col_zero) begin
                w_pred[c] = i_above[c];
            end else begin
                w_pred[c] = w_prod[c][RECIP3_SHIFT +: PIX_W];
            end

            w_diff[c] = RES_W'(i_cur[c]) - RES_W'(w_pred[c]);
            w_neg[c]  = RES_W'(0) - w_diff[c];

            o_res.resid[c] = w_diff[c];
            o_res.mag[c]   = w_diff[c][RES_W-1] ? w_neg[c][PIX_W-1:0]
                                                : w_diff[c][PIX_W-1:0];
        end
    end

endmodule

// ===== design/prbgp_div.sv =====
`timescale 1ns / 1ps

module prbgp_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  prbgp_pkg::t_div_req               i_req,
    output logic                              o_done,
    output logic [prbgp_pkg::NCH-1:0][prbgp_pkg::PAR_W-1:0] o_param
);

    import prbgp_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);
    localparam int REM_W  = CNT_W + 1;

    logic                      r_busy;
    logic                      r_done;
    logic [STEP_W-1:0]         r_step;
    logic [CNT_W-1:0]          r_divisor;
    logic [NCH-1:0][CNT_W-1:0] r_rem;
    logic [NCH-1:0][SUM_W-1:0] r_quo;

    logic [NCH-1:0][REM_W-1:0] w_trial;
    logic [NCH-1:0]            w_fits;
    logic                      w_last;

    // One restoring step per lane and cycle; the dividend shifts out as
    // the quotient shifts in.
    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            w_trial[c] = {r_rem[c], r_quo[c][SUM_W-1]};
            w_fits[c]  = w_trial[c] >= REM_W'(r_divisor);
        end
    end

    assign w_last = r_step == STEP_W'(SUM_W - 1);

    // Control: start loads the lanes, the last step raises done for a cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Lane data.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_divisor <= i_req.divisor;
            r_rem     <= '0;
            r_quo     <= i_req.dividend;
        end else if (r_busy) begin
            for (int c = 0; c < NCH; c++) begin
                if (w_fits[c]) begin
                    r_rem[c] <= CNT_W'(w_trial[c] - REM_W'(r_divisor));
                end else begin
                    r_rem[c] <= w_trial[c][CNT_W-1:0];
                end
                r_quo[c] <= {r_quo[c][SUM_W-2:0], w_fits[c]};
            end
        end
    end

    // The mean is clamped to the range of one to 255.
    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            if (r_quo[c] == '0) begin
                o_param[c] = PAR_W'(1);
            end else if (r_quo[c][SUM_W-1:PAR_W] != '0) begin
                o_param[c] = '1;
            end else begin
                o_param[c] = r_quo[c][PAR_W-1:0];
            end
        end
    end

    assign o_done = r_done;

endmodule

// ===== verif/tb_pixel_residual_block_golomb_param.sv =====
`timescale 1ns / 1ps

module tb_pixel_residual_block_golomb_param;

    import prbgp_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_ITEMS = 1450;

    // One expected output transaction.
    typedef struct packed {
        logic [NCH-1:0][RES_W-1:0] resid;
        logic                      done;
        logic [NCH-1:0][PAR_W-1:0] param;
    } t_expected_pixel;

    // Block ports; the inputs are all driven to known values from time zero.
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // chan_luma, chan_red_diff, chan_blue_diff
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // frame_start
    logic [0:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    // resid_luma, resid_red_diff, resid_blue_diff, param_luma,
    // param_red_diff, param_blue_diff, zero padding
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // block_done
    logic [0:0]            m_axis_tuser;

    // Shadow of the block's registers and state.
    logic [IWID_W-1:0]     cfg_width = IWID_W'(640);
    logic [CNT_W-1:0]      cfg_bsize = CNT_W'(640);
    logic                  cfg_adapt = 1'b0;
    t_pixel                row_store [MAX_WIDTH];
    bit                    row_written [MAX_WIDTH];
    t_pixel                left_pix = '0;
    t_pixel                ul_pix = '0;
    int unsigned           col_pos = 0;
    logic                  first_row = 1'b1;
    logic [CNT_W-1:0]      blk_count = '0;
    logic [SUM_W-1:0]      abs_sum [NCH];

    t_expected_pixel       expected_results [$];
    t_expected_pixel       front;
    int                    err_count = 0;
    int                    cycle_count = 0;
    bit                    gaps_on = 1'b0;
    int unsigned           stall_left = 0;

    pixel_residual_block_golomb_param uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock generation.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Run-length guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("pixel_residual_block_golomb_param regression: fail");
            $finish;
        end
    end

    function automatic t_pixel mk_pixel(input int luma, input int red, input int blue);
        t_pixel px;
        px[0] = luma[PIX_W-1:0];
        px[1] = red[PIX_W-1:0];
        px[2] = blue[PIX_W-1:0];
        return px;
    endfunction

    // Works out the residuals and any block parameters for one pixel and
    // queues them, advancing the shadow state as the block would.
    function automatic void predict_residuals(input logic frame, input t_pixel px);
        t_expected_pixel e;
        int unsigned     width;
        int unsigned     bsize;
        int unsigned     column;
        int unsigned     mean;
        int              pred;
        int              r;
        t_pixel          above;
        if (frame) begin
            col_pos   = 0;
            first_row = 1'b1;
            blk_count = '0;
            for (int c = 0; c < NCH; c++) abs_sum[c] = '0;
        end
        width = cfg_width;
        if (width == 0) width = 1;
        if (width > MAX_WIDTH) width = MAX_WIDTH;
        column = (col_pos >= MAX_WIDTH) ? 0 : col_pos;
        above = row_store[column];
        e = '0;

        for (int c = 0; c < NCH; c++) begin
            if (first_row && column == 0) begin
                pred = 0;
            end else if (first_row) begin
                pred = int'(left_pix[c]);
            end else if (column == 0) begin
                pred = int'(above[c]);
            end else begin
                pred = (int'(left_pix[c]) + int'(above[c]) + int'(ul_pix[c])) / 3;
            end
            r = int'(px[c]) - pred;
            abs_sum[c] = abs_sum[c] + SUM_W'((r < 0) ? -r : r);
            e.resid[c] = r[RES_W-1:0];
        end

        // The entry read now becomes the next upper-left neighbour.
        ul_pix = above;
        row_store[column] = px;
        row_written[column] = 1'b1;
        left_pix = px;
        if (column + 1 >= width) begin
            col_pos   = 0;
            first_row = 1'b0;
        end else begin
            col_pos = column + 1;
        end

        bsize = cfg_bsize;
        if (bsize == 0) bsize = 1;
        blk_count = blk_count + 1'b1;
        if (blk_count >= bsize) begin
            if (cfg_adapt) begin
                e.done = 1'b1;
                for (int c = 0; c < NCH; c++) begin
                    mean = abs_sum[c] / bsize;
                    if (mean < 1) mean = 1;
                    if (mean > 255) mean = 255;
                    e.param[c] = mean[PAR_W-1:0];
                end
            end
            blk_count = '0;
            for (int c = 0; c < NCH; c++) abs_sum[c] = '0;
        end
        expected_results.insert(expected_results.size(), e);
    endfunction

    // Sends one pixel transaction. A pixel that would read a previous-row
    // entry never written is turned into the start of a new image.
    task automatic send_pixel(input logic fs, input t_pixel px);
        logic        frame;
        int unsigned idle;
        frame = fs;
        if (!frame && !first_row && !row_written[col_pos]) frame = 1'b1;
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            idle = $urandom_range(1, 10);
            s_axis_tvalid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        predict_residuals(frame, px);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        s_axis_tuser  <= frame;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Lets every outstanding result leave the block.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        case (idx)
            CFG_IMAGE_WIDTH: cfg_width = value[IWID_W-1:0];
            CFG_BLOCK_SIZE:  cfg_bsize = value;
            CFG_ADAPTIVE:    cfg_adapt = value[0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Checks each output transaction and paces the receiver.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h",
                         $time, m_axis_tdata);
                err_count++;
            end else begin
                front = expected_results.pop_front();
                for (int c = 0; c < NCH; c++) begin
                    if (m_axis_tdata[c*RES_W +: RES_W] !== front.resid[c]) begin
                        $display("%0t: residual ch%0d expected %0d actual %0d", $time, c,
                                 $signed(front.resid[c]),
                                 $signed(m_axis_tdata[c*RES_W +: RES_W]));
                        err_count++;
                    end
                    if (m_axis_tdata[NCH*RES_W + c*PAR_W +: PAR_W] !== front.param[c]) begin
                        $display("%0t: parameter ch%0d expected %0d actual %0d", $time, c,
                                 front.param[c], m_axis_tdata[NCH*RES_W + c*PAR_W +: PAR_W]);
                        err_count++;
                    end
                end
                if (m_axis_tuser[0] !== front.done) begin
                    $display("%0t: block_done expected %0b actual %0b",
                             $time, front.done, m_axis_tuser[0]);
                    err_count++;
                end
            end
        end
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left    <= $urandom_range(0, 9);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Register defaults; no frame start is sent before the first pixels.
    task automatic test_reset_state();
        send_pixel(1'b0, mk_pixel(0, 128, 255));
        send_pixel(1'b0, mk_pixel(255, 0, 7));
        wait_idle();
    endtask

    // Full-scale residuals of both signs and every prediction case.
    task automatic test_residual_extremes();
        write_reg(CFG_IMAGE_WIDTH, 16'd4);
        write_reg(CFG_BLOCK_SIZE, 16'd4);
        write_reg(CFG_ADAPTIVE, 16'd1);
        send_pixel(1'b1, mk_pixel(255, 0, 255));
        send_pixel(1'b0, mk_pixel(0, 255, 0));
        send_pixel(1'b0, mk_pixel(255, 0, 255));
        send_pixel(1'b0, mk_pixel(0, 0, 0));
        send_pixel(1'b0, mk_pixel(255, 255, 255));
        send_pixel(1'b0, mk_pixel(0, 0, 0));
        wait_idle();
    endtask

    // Zero width and zero block size act as one; an oversized width is clamped.
    // A block of zero residuals gives the minimum parameter.
    task automatic test_degenerate_sizes();
        write_reg(CFG_IMAGE_WIDTH, 16'd0);
        write_reg(CFG_BLOCK_SIZE, 16'd0);
        send_pixel(1'b1, mk_pixel(0, 0, 0));
        send_pixel(1'b0, mk_pixel(200, 3, 90));
        send_pixel(1'b0, mk_pixel(200, 3, 90));
        wait_idle();
        write_reg(CFG_IMAGE_WIDTH, 16'd8191);
        write_reg(CFG_BLOCK_SIZE, 16'd65535);
        send_pixel(1'b1, mk_pixel(17, 34, 51));
        send_pixel(1'b0, mk_pixel(1, 250, 128));
        wait_idle();
    endtask

    // Narrowing the width mid-row wraps the row at once.
    task automatic test_width_change();
        write_reg(CFG_IMAGE_WIDTH, 16'd6);
        write_reg(CFG_BLOCK_SIZE, 16'd5);
        send_pixel(1'b1, mk_pixel(10, 20, 30));
        send_pixel(1'b0, mk_pixel(40, 50, 60));
        send_pixel(1'b0, mk_pixel(70, 80, 90));
        send_pixel(1'b0, mk_pixel(100, 110, 120));
        wait_idle();
        write_reg(CFG_IMAGE_WIDTH, 16'd3);
        send_pixel(1'b0, mk_pixel(5, 15, 25));
        send_pixel(1'b0, mk_pixel(99, 1, 200));
        send_pixel(1'b0, mk_pixel(33, 66, 9));
        wait_idle();
    endtask

    // Shrinking the block size mid-block ends it at once; the mean saturates.
    task automatic test_block_shrink();
        write_reg(CFG_IMAGE_WIDTH, 16'd16);
        write_reg(CFG_BLOCK_SIZE, 16'd10);
        send_pixel(1'b1, mk_pixel(0, 0, 0));
        send_pixel(1'b0, mk_pixel(255, 255, 255));
        send_pixel(1'b0, mk_pixel(0, 0, 0));
        send_pixel(1'b0, mk_pixel(255, 255, 255));
        send_pixel(1'b0, mk_pixel(0, 0, 0));
        wait_idle();
        write_reg(CFG_BLOCK_SIZE, 16'd1);
        send_pixel(1'b0, mk_pixel(255, 255, 255));
        wait_idle();
    endtask

    // With adaptive mode off the blocks still count but flag nothing.
    task automatic test_adaptive_off();
        write_reg(CFG_ADAPTIVE, 16'd0);
        write_reg(CFG_BLOCK_SIZE, 16'd2);
        send_pixel(1'b0, mk_pixel(12, 240, 77));
        send_pixel(1'b0, mk_pixel(13, 200, 78));
        send_pixel(1'b0, mk_pixel(250, 2, 0));
        wait_idle();
    endtask

    // Random images under random settings, mostly well-formed frames.
    task automatic test_random_frames();
        int unsigned sent;
        int unsigned n;
        int unsigned style;
        int          d;
        int          v;
        logic        fs;
        t_pixel      px;
        t_pixel      prev_px;
        sent = 0;
        prev_px = mk_pixel(128, 128, 128);
        while (sent < RANDOM_ITEMS) begin
            gaps_on = (sent < RANDOM_ITEMS * 85 / 100) && ($urandom_range(0, 5) != 0);

            // New settings while the block is idle.
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 9))
                    0: write_reg(CFG_IMAGE_WIDTH, 16'd0);
                    1: write_reg(CFG_IMAGE_WIDTH, 16'd1);
                    2: write_reg(CFG_IMAGE_WIDTH, 16'($urandom_range(2, 4)));
                    3, 4, 5: write_reg(CFG_IMAGE_WIDTH, 16'($urandom_range(2, 16)));
                    6: write_reg(CFG_IMAGE_WIDTH, 16'($urandom_range(17, 64)));
                    7: write_reg(CFG_IMAGE_WIDTH, 16'(MAX_WIDTH));
                    8: write_reg(CFG_IMAGE_WIDTH, 16'($urandom_range(MAX_WIDTH + 1, 8191)));
                    default: write_reg(CFG_IMAGE_WIDTH, 16'($urandom_range(1, 8191)));
                endcase
            end
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 9))
                    0: write_reg(CFG_BLOCK_SIZE, 16'd0);
                    1: write_reg(CFG_BLOCK_SIZE, 16'd1);
                    2, 3, 4, 5, 6: write_reg(CFG_BLOCK_SIZE, 16'($urandom_range(2, 24)));
                    7: write_reg(CFG_BLOCK_SIZE, 16'($urandom_range(25, 300)));
                    8: write_reg(CFG_BLOCK_SIZE, 16'd65535);
                    default: write_reg(CFG_BLOCK_SIZE, 16'($urandom_range(0, 65535)));
                endcase
            end
            if ($urandom_range(0, 2) == 0) begin
                write_reg(CFG_ADAPTIVE, ($urandom_range(0, 3) != 0) ? 16'd1 : 16'd0);
            end

            // One frame, sometimes continuing the previous one.
            n = $urandom_range(8, 60);
            style = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) begin
                if (i == 0) fs = ($urandom_range(0, 5) != 0);
                else        fs = ($urandom_range(0, 40) == 0);
                for (int c = 0; c < NCH; c++) begin
                    case (style)
                        0: v = $urandom_range(0, 255);
                        1: begin
                            d = $urandom_range(0, 8);
                            v = int'(prev_px[c]) + d - 4;
                            if (v < 0) v = 0;
                            if (v > 255) v = 255;
                        end
                        2: v = ($urandom_range(0, 1) != 0) ? 255 : 0;
                        default: v = ($urandom_range(0, 7) == 0) ?
                                     $urandom_range(0, 255) : int'(prev_px[c]);
                    endcase
                    px[c] = v[PIX_W-1:0];
                end
                send_pixel(fs, px);
                prev_px = px;
                sent++;
            end
            wait_idle();
        end
        gaps_on = 1'b0;
    endtask

    initial begin
        for (int c = 0; c < NCH; c++) abs_sum[c] = '0;
        for (int a = 0; a < MAX_WIDTH; a++) begin
            row_store[a]   = '0;
            row_written[a] = 1'b0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_residual_extremes();
        test_degenerate_sizes();
        test_width_change();
        test_block_shrink();
        test_adaptive_off();
        test_random_frames();

        // Drain, then allow for the divider latency before the verdict.
        wait_idle();
        repeat (40) @(posedge i_clk);
        if (err_count == 0 && expected_results.size() == 0) begin
            $display("pixel_residual_block_golomb_param regression: pass");
        end else begin
            $display("pixel_residual_block_golomb_param regression: fail");
        end
        $finish;
    end

endmodule

// ===== pixel_residual_block_golomb_param.f =====
+incdir+design
design/prbgp_pkg.sv
design/prbgp_ram.sv
design/prbgp_pred.sv
design/prbgp_div.sv
design/pixel_residual_block_golomb_param.sv
verif/tb_pixel_residual_block_golomb_param.sv
